// ===== src/dpls_pkg.sv =====
// Shared constants, register indexes and width helpers for the point-light shader.
`timescale 1ns / 1ps
package dpls_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int NORMAL_FRAC_DEF = 14;
	localparam int NORMAL_W        = 16;
	localparam int RANGE_W         = 12;
	localparam int ATT_FRAC        = 14;
	localparam int CQ_BITS         = 16;	// |cosine| stays below 2^16 for any 16-bit normal
	localparam int NUM_LIGHTS      = 4;
	localparam int CFG_IDX_W       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RED_XY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_XY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_XY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_XY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE    = 3'd5;

	// root bits of sqrt(magsq * 256)
	function automatic int sqrt_bits(input int cb);
		return cb + 5;
	endfunction

	// quotient bits of the attenuation divide
	function automatic int att_q_bits(input int cb);
		return ((cb + 5) > 16 ? (cb + 5) : 16) + 10;
	endfunction

	function automatic int prod_bits(input int cb);
		return CQ_BITS + att_q_bits(cb) + 2;
	endfunction

	function automatic int term_bits(input int cb, input int nfb);
		return prod_bits(cb) + 9 - (nfb + ATT_FRAC - 8);
	endfunction

	// register stages inside one light unit
	function automatic int light_depth(input int cb);
		return sqrt_bits(cb) + att_q_bits(cb) + 7;
	endfunction

endpackage

// ===== src/dpls_light.sv =====
// Pipelined Lambert term of one point light: vector, sqrt, two divides, scaling.
`timescale 1ns / 1ps
module dpls_light #(
	parameter int COORD_BITS       = dpls_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = dpls_pkg::NORMAL_FRAC_DEF
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [COORD_BITS-1:0]          px,
	input  logic signed [COORD_BITS-1:0]          py,
	input  logic signed [dpls_pkg::NORMAL_W-1:0]  nx,
	input  logic signed [dpls_pkg::NORMAL_W-1:0]  ny,
	input  logic [2*COORD_BITS-1:0]               lxy,
	input  logic [dpls_pkg::RANGE_W+3:0]          r16,
	output logic signed [dpls_pkg::term_bits(COORD_BITS, NORMAL_FRAC_BITS)-1:0] term
);
	import dpls_pkg::*;

	localparam int LW   = COORD_BITS + 1;
	localparam int MW   = 2 * COORD_BITS + 1;
	localparam int DW   = COORD_BITS + 18;
	localparam int SQW  = sqrt_bits(COORD_BITS);
	localparam int RADW = 2 * SQW;
	localparam int REMW = SQW + 2;
	localparam int AQ   = att_q_bits(COORD_BITS);
	localparam int DFW  = AQ - 10;
	localparam int N1W  = DW + 4;
	localparam int R1W  = SQW + 1;
	localparam int R2W  = RANGE_W + 5;
	localparam int N2W  = DFW + ATT_FRAC;
	localparam int PW   = prod_bits(COORD_BITS);
	localparam int XW   = PW + 8;
	localparam int SH   = NORMAL_FRAC_BITS + ATT_FRAC - 8;
	localparam int TW   = term_bits(COORD_BITS, NORMAL_FRAC_BITS);

	// s2: light vector
	logic signed [LW-1:0]       lx_s2, ly_s2;
	logic signed [NORMAL_W-1:0] nx_s2, ny_s2;
	// s3: products
	logic signed [2*LW-1:0]        xx_s3, yy_s3;
	logic signed [LW+NORMAL_W-1:0] xn_s3, yn_s3;
	logic [2*LW-1:0]               mag_sum;
	logic [MW-1:0]                 magsq;

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s2 <= LW'(signed'(lxy[COORD_BITS-1:0])) - LW'(px);
			ly_s2 <= LW'(signed'(lxy[2*COORD_BITS-1:COORD_BITS])) - LW'(py);
			nx_s2 <= nx;
			ny_s2 <= ny;
			xx_s3 <= lx_s2 * lx_s2;
			yy_s3 <= ly_s2 * ly_s2;
			xn_s3 <= LW'(lx_s2) * nx_s2;
			yn_s3 <= LW'(ly_s2) * ny_s2;
		end
	end

	// both light position fields are sign-extended before the subtract
	assign mag_sum = xx_s3 + yy_s3;
	assign magsq   = mag_sum[MW-1:0];

	// sqrt pipeline, one root bit per stage; index 0 is s4
	logic [RADW-1:0]       sq_rad_s  [SQW+1];
	logic [REMW-1:0]       sq_rem_s  [SQW+1];
	logic [SQW-1:0]        sq_root_s [SQW+1];
	logic signed [DW-1:0]  sq_dot_s  [SQW+1];
	logic                  sq_zero_s [SQW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad_s[0]  <= RADW'({magsq, 8'd0});
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_dot_s[0]  <= DW'(xn_s3) + DW'(yn_s3);
			sq_zero_s[0] <= (magsq == '0);
		end
	end

	for (genvar k = 0; k < SQW; k++) begin : g_sqrt
		logic [REMW+1:0] rr, trial;
		logic            ge;
		assign rr    = {sq_rem_s[k], sq_rad_s[k][RADW-1:RADW-2]};
		assign trial = (REMW+2)'({sq_root_s[k], 2'b01});
		assign ge    = rr >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
				sq_rem_s[k+1]  <= ge ? REMW'(rr - trial) : REMW'(rr);
				sq_root_s[k+1] <= {sq_root_s[k][SQW-2:0], ge};
				sq_dot_s[k+1]  <= sq_dot_s[k];
				sq_zero_s[k+1] <= sq_zero_s[k];
			end
		end
	end

	// divide setup: magnitudes and signs of dot*16 and (R*16 - dq)
	logic [SQW-1:0]          dq;
	logic signed [DW-1:0]    dot;
	logic [DW-1:0]           dot_mag;
	logic [N1W-1:0]          n1;
	logic signed [DFW:0]     diff;
	logic [DFW-1:0]          diff_mag;
	logic [N2W-1:0]          n2;

	assign dq       = sq_root_s[SQW];
	assign dot      = sq_dot_s[SQW];
	assign dot_mag  = dot[DW-1] ? DW'(-dot) : DW'(dot);
	assign n1       = {dot_mag, 4'd0};
	assign diff     = signed'((DFW+1)'(r16)) - signed'((DFW+1)'(dq));
	assign diff_mag = diff[DFW] ? DFW'(-diff) : DFW'(diff);
	assign n2       = {diff_mag, ATT_FRAC'(0)};

	// restoring dividers, CQ_BITS and AQ quotient bits, one per stage; 0 is setup
	logic [R1W-1:0]     d1_rem_s  [AQ+1];
	logic [CQ_BITS-1:0] d1_bits_s [AQ+1];
	logic [CQ_BITS-1:0] d1_q_s    [AQ+1];
	logic               d1_neg_s  [AQ+1];
	logic [SQW-1:0]     dq_s      [AQ+1];
	logic [R2W-1:0]     d2_rem_s  [AQ+1];
	logic [AQ-1:0]      d2_bits_s [AQ+1];
	logic [AQ-1:0]      d2_q_s    [AQ+1];
	logic               d2_neg_s  [AQ+1];
	logic               dv_zero_s [AQ+1];

	always_ff @(posedge clk) begin
		if (en) begin
			d1_rem_s[0]  <= R1W'(n1 >> CQ_BITS);
			d1_bits_s[0] <= n1[CQ_BITS-1:0];
			d1_q_s[0]    <= '0;
			d1_neg_s[0]  <= dot[DW-1];
			dq_s[0]      <= dq;
			d2_rem_s[0]  <= R2W'(n2 >> AQ);
			d2_bits_s[0] <= n2[AQ-1:0];
			d2_q_s[0]    <= '0;
			d2_neg_s[0]  <= diff[DFW];
			dv_zero_s[0] <= sq_zero_s[SQW];
		end
	end

	for (genvar j = 0; j < AQ; j++) begin : g_div
		logic [R1W-1:0] sh1;
		logic [R2W-1:0] sh2;
		logic           ge1, ge2;
		assign sh1 = {d1_rem_s[j][R1W-2:0], d1_bits_s[j][CQ_BITS-1]};
		assign ge1 = sh1 >= R1W'(dq_s[j]);
		assign sh2 = {d2_rem_s[j][R2W-2:0], d2_bits_s[j][AQ-1]};
		assign ge2 = sh2 >= R2W'(r16);
		always_ff @(posedge clk) begin
			if (en) begin
				if (j < CQ_BITS) begin
					d1_rem_s[j+1]  <= ge1 ? sh1 - R1W'(dq_s[j]) : sh1;
					d1_bits_s[j+1] <= d1_bits_s[j] << 1;
					d1_q_s[j+1]    <= {d1_q_s[j][CQ_BITS-2:0], ge1};
				end else begin
					d1_rem_s[j+1]  <= d1_rem_s[j];
					d1_bits_s[j+1] <= d1_bits_s[j];
					d1_q_s[j+1]    <= d1_q_s[j];
				end
				d1_neg_s[j+1]  <= d1_neg_s[j];
				dq_s[j+1]      <= dq_s[j];
				d2_rem_s[j+1]  <= ge2 ? sh2 - R2W'(r16) : sh2;
				d2_bits_s[j+1] <= d2_bits_s[j] << 1;
				d2_q_s[j+1]    <= {d2_q_s[j][AQ-2:0], ge2};
				d2_neg_s[j+1]  <= d2_neg_s[j];
				dv_zero_s[j+1] <= dv_zero_s[j];
			end
		end
	end

	// cosine * attenuation, then *255, then truncating shift
	logic signed [CQ_BITS:0] cosv;
	logic signed [AQ:0]      attv;
	logic signed [PW-1:0]    prod_m;
	logic                    zero_m;
	logic signed [XW-1:0]    x_x, xb;
	logic                    zero_x;
	logic signed [XW-1:0]    pe;

	assign cosv = d1_neg_s[AQ] ? -signed'({1'b0, d1_q_s[AQ]}) : signed'({1'b0, d1_q_s[AQ]});
	assign attv = d2_neg_s[AQ] ? -signed'({1'b0, d2_q_s[AQ]}) : signed'({1'b0, d2_q_s[AQ]});
	assign pe   = XW'(prod_m);
	assign xb   = x_x + (x_x[XW-1] ? signed'({{(XW-SH){1'b0}}, {SH{1'b1}}}) : signed'(XW'(0)));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_m <= PW'(cosv) * PW'(attv);
			zero_m <= dv_zero_s[AQ];
			x_x    <= (pe <<< 8) - pe;
			zero_x <= zero_m;
			term   <= zero_x ? '0 : TW'(xb >>> SH);
		end
	end

endmodule

// ===== src/diffuse_point_light_shader_unit.sv =====
// Top level of the diffuse point-light shader: config registers, four light pipes, sum, clamp.
// Throughput: one word per cycle while in_stall is low; all four lights run in parallel fully pipelined units.
// Latency is set by the bit-per-stage sqrt and the attenuation divide.
// A two-deep output buffer takes one more word; then a stalled result stalls pipe and input.
// Reset (arst_n low) clears valids and loads the register defaults.
`timescale 1ns / 1ps
module diffuse_point_light_shader_unit #(
	parameter int COORD_BITS       = dpls_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = dpls_pkg::NORMAL_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dpls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [2*COORD_BITS-1:0]              cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         point_x,
	input  logic signed [COORD_BITS-1:0]         point_y,
	input  logic signed [dpls_pkg::NORMAL_W-1:0] normal_x,
	input  logic signed [dpls_pkg::NORMAL_W-1:0] normal_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue
);
	import dpls_pkg::*;

	localparam int CW  = 2 * COORD_BITS;
	localparam int LAT = light_depth(COORD_BITS);
	localparam int TW  = term_bits(COORD_BITS, NORMAL_FRAC_BITS);
	localparam int AW  = TW + 1;

	logic [CW-1:0]         xy_q [NUM_LIGHTS];
	logic [NUM_LIGHTS-1:0] enable_q;
	logic [RANGE_W-1:0]    range_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_q[0]  <= CW'(150);
			xy_q[1]  <= CW'(200);
			xy_q[2]  <= CW'(250);
			xy_q[3]  <= CW'(300);
			enable_q <= '1;
			range_q  <= RANGE_W'(350);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RED_XY:   xy_q[0]  <= cfg_data;
				REG_GREEN_XY: xy_q[1]  <= cfg_data;
				REG_BLUE_XY:  xy_q[2]  <= cfg_data;
				REG_WHITE_XY: xy_q[3]  <= cfg_data;
				REG_ENABLE:   enable_q <= cfg_data[NUM_LIGHTS-1:0];
				REG_RANGE:    range_q  <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// zero range behaves as one pixel
	logic [RANGE_W-1:0] rng;
	logic [RANGE_W+3:0] r16;
	assign rng = (range_q == '0) ? RANGE_W'(1) : range_q;
	assign r16 = {rng, 4'd0};

	// pipe advances unless the skid word is held
	logic en;
	logic sk_v_q;
	assign en       = !sk_v_q;
	assign in_stall = sk_v_q;

	logic signed [COORD_BITS-1:0] px_s1, py_s1;
	logic signed [NORMAL_W-1:0]   nx_s1, ny_s1;
	logic                         v_s [LAT+1];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= point_x;
			py_s1 <= point_y;
			nx_s1 <= normal_x;
			ny_s1 <= normal_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAT; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 0; i < LAT; i++) v_s[i+1] <= v_s[i];
		end
	end

	logic signed [TW-1:0] term [NUM_LIGHTS];
	logic signed [TW-1:0] te   [NUM_LIGHTS];

	for (genvar g = 0; g < NUM_LIGHTS; g++) begin : g_light
		dpls_light #(
			.COORD_BITS      (COORD_BITS),
			.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
		) u_light (
			.clk (clk),
			.en  (en),
			.px  (px_s1),
			.py  (py_s1),
			.nx  (nx_s1),
			.ny  (ny_s1),
			.lxy (xy_q[g]),
			.r16 (r16),
			.term(term[g])
		);
		assign te[g] = enable_q[g] ? term[g] : '0;
	end

	// white feeds every channel
	logic signed [AW-1:0] acc_r_q, acc_g_q, acc_b_q;
	logic                 acc_v_q;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_r_q <= AW'(te[0]) + AW'(te[3]);
			acc_g_q <= AW'(te[1]) + AW'(te[3]);
			acc_b_q <= AW'(te[2]) + AW'(te[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_v_q <= 1'b0;
		else if (en) acc_v_q <= v_s[LAT];
	end

	function automatic logic [7:0] clamp8(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] v;
		v = a >>> 8;
		if (a <= 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	logic [23:0] rgb_new;
	logic [23:0] out_q, sk_q;
	logic        out_v_q;
	logic        arr, take;

	assign rgb_new = {clamp8(acc_r_q), clamp8(acc_g_q), clamp8(acc_b_q)};
	assign arr     = en && acc_v_q;
	assign take    = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (take) sk_v_q <= 1'b0;
		end else if (arr) begin
			if (out_v_q && !take) sk_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (take) out_q <= sk_q;
		end else if (arr) begin
			if (out_v_q && !take) sk_q <= rgb_new;
			else out_q <= rgb_new;
		end
	end

	assign out_valid = out_v_q;
	assign red       = out_q[23:16];
	assign green     = out_q[15:8];
	assign blue      = out_q[7:0];

endmodule
